[hw/rtl/hli_pkg.sv]
// Shared types, codes and constants for the hashed log index.
package hli_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;
    localparam int unsigned INDEX_ENTRIES_DEF = 1024;

    localparam logic [31:0] OFF_TOMB      = 32'hFFFF_FFFF;
    localparam logic [31:0] LOG_START_RST = 32'd65536;
    localparam logic [31:0] LOG_END_RST   = 32'd1073741824;

    localparam logic [1:0] REQ_GET  = 2'd0;
    localparam logic [1:0] REQ_PUT  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] CFG_LOG_START = 2'd0;
    localparam logic [1:0] CFG_LOG_END   = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [63:0] key_digest;
        logic [31:0] tag;
        logic [31:0] search_tag;
        logic [31:0] record_bytes;
        logic [63:0] version;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] record_offset;
        logic [63:0] found_version;
    } t_result;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] offset;
        logic [63:0] key;
        logic [63:0] version;
    } t_bucket;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_SETUP, S_READ, S_EVAL, S_WRITE
    } t_state;

    typedef enum logic [2:0] {
        FIN_NONE, FIN_MISS, FIN_FULL, FIN_GET, FIN_PUT, FIN_DEL
    } t_fin;

    typedef struct packed {
        logic clr;
        logic load;
        logic mod_step;
        logic init;
        logic rd;
        logic eval;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       mod_last;
        logic [1:0] req_type;
        logic       put_room;
        logic       del_room;
        logic       done;
        logic       hit;
        logic       have;
    } t_stat;

endpackage

[hw/rtl/hli_ctrl.sv]
// Request sequencer: clear pass, home bucket reduction, probe loop, write back.
module hli_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  hli_pkg::t_stat i_stat,
    output hli_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import hli_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_MOD;
            end
            S_MOD: begin
                if (i_stat.mod_last) n_state = S_SETUP;
            end
            S_SETUP: begin
                case (i_stat.req_type)
                    REQ_GET, REQ_DEL: n_state = S_READ;
                    REQ_PUT: n_state = i_stat.put_room ? S_READ : S_IDLE;
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (!i_stat.done) begin
                    n_state = S_READ;
                end else begin
                    case (i_stat.req_type)
                        REQ_PUT: n_state = i_stat.have ? S_WRITE : S_IDLE;
                        REQ_DEL: n_state = (i_stat.hit && i_stat.del_room) ? S_WRITE : S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '{default: '0, fin: FIN_NONE};
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: o_cmd.load = i_start;
            S_MOD: o_cmd.mod_step = 1'b1;
            S_SETUP: begin
                case (i_stat.req_type)
                    REQ_GET, REQ_DEL: o_cmd.init = 1'b1;
                    REQ_PUT: begin
                        if (i_stat.put_room) o_cmd.init = 1'b1;
                        else o_cmd.fin = FIN_FULL;
                    end
                    default: o_cmd.fin = FIN_MISS;
                endcase
            end
            S_READ: o_cmd.rd = 1'b1;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.done) begin
                    case (i_stat.req_type)
                        REQ_GET: o_cmd.fin = i_stat.hit ? FIN_GET : FIN_MISS;
                        REQ_PUT: begin
                            if (!i_stat.have) o_cmd.fin = FIN_FULL;
                        end
                        REQ_DEL: begin
                            if (!i_stat.hit) o_cmd.fin = FIN_MISS;
                            else if (!i_stat.del_room) o_cmd.fin = FIN_FULL;
                        end
                        default: o_cmd.fin = FIN_MISS;
                    endcase
                end
            end
            S_WRITE: o_cmd.fin = (i_stat.req_type == REQ_PUT) ? FIN_PUT : FIN_DEL;
            default: ;
        endcase
    end

endmodule

[hw/rtl/hli_dp.sv]
// Datapath: bucket memory, hash reduction, probe registers, log pointers.
module hli_dp #(
    parameter int unsigned TABLE_ENTRIES = hli_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned INDEX_ENTRIES = hli_pkg::INDEX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hli_pkg::t_request i_request,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  hli_pkg::t_cmd     i_cmd,
    output hli_pkg::t_stat    o_stat,
    output hli_pkg::t_result  o_result,
    output logic              o_strobe
);
    import hli_pkg::*;

    // weight of each hash byte: 256^i mod TABLE_ENTRIES
    function automatic logic [7:0][31:0] byte_weights();
        logic [7:0][31:0] t;
        longint unsigned  w;
        w = 64'd1 % 64'(TABLE_ENTRIES);
        for (int i = 0; i < 8; i++) begin
            t[i] = 32'(w);
            w = (w * 64'd256) % 64'(TABLE_ENTRIES);
        end
        return t;
    endfunction

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned IW = (INDEX_ENTRIES > 1) ? $clog2(INDEX_ENTRIES) : 1;
    localparam int unsigned MW = 4;
    localparam int unsigned FOLD_SHIFT = 10;
    localparam logic [MW-1:0] MOD_LAST = MW'(FOLD_SHIFT + 1);
    localparam logic [31:0]   TAB32    = 32'(TABLE_ENTRIES);
    localparam logic [31:0]   TOP_DIV  = TAB32 << FOLD_SHIFT;
    localparam logic [7:0][31:0] WGT   = byte_weights();
    localparam logic [AW-1:0] LAST_B   = AW'(TABLE_ENTRIES - 1);
    localparam logic [IW-1:0] ICNT_MAX = IW'(INDEX_ENTRIES - 1);

    t_bucket r_mem [TABLE_ENTRIES];
    t_bucket r_rd;
    t_bucket r_word;

    t_request      r_req;
    logic [31:0]   r_log_end;
    logic [31:0]   r_append;
    logic [IW-1:0] r_icnt;
    logic [AW-1:0] r_clr_addr;
    logic [MW-1:0] r_mcnt;
    logic [31:0]   r_fold;
    logic [31:0]   r_div;
    logic [AW-1:0] r_b;
    logic [AW-1:0] r_n;
    logic [AW-1:0] r_dead;
    logic          r_dead_ok;
    logic [AW-1:0] r_slot;
    t_result       r_res;
    logic          r_strobe;

    logic [31:0]   fold_sum;
    logic [32:0]   put_end;
    logic [33:0]   put_next;
    logic [32:0]   del_end;
    logic          tag_eq, tomb, empty, hit, last;
    logic [AW-1:0] dead1, dead2, slot;
    logic          ok1, ok2, have;
    logic          we;
    logic [AW-1:0] waddr;
    t_bucket       wdata;

    // fold the hash bytes by their weights; the sum stays below 2048 table sizes
    always_comb begin
        fold_sum = '0;
        for (int i = 0; i < 8; i++) begin
            fold_sum = fold_sum + {24'd0, r_req.key_digest[8*i +: 8]} * WGT[i];
        end
    end

    assign put_end  = {1'b0, r_append} + {1'b0, r_req.record_bytes};
    assign put_next = ({1'b0, put_end} + 34'd7) & ~34'd7;
    assign del_end  = {1'b0, r_append} + 33'd8;

    always_comb begin
        tag_eq = (r_rd.tag == r_req.tag);
        tomb   = (r_rd.offset == OFF_TOMB);
        empty  = (r_rd.offset == 32'd0);
        last   = (r_n == LAST_B);
        dead1  = r_dead;
        ok1    = r_dead_ok;
        if (tag_eq && tomb) begin
            dead1 = r_b;
            ok1   = 1'b1;
        end
        hit   = tag_eq && !tomb && !empty && (r_rd.key == r_req.key);
        dead2 = dead1;
        ok2   = ok1;
        if (tomb && !ok1) begin
            dead2 = r_b;
            ok2   = 1'b1;
        end
        if (hit) begin
            slot = r_b;
            have = 1'b1;
        end else if (empty) begin
            slot = ok1 ? dead1 : r_b;
            have = 1'b1;
        end else begin
            slot = dead2;
            have = ok2;
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr_addr == LAST_B);
        o_stat.mod_last = (r_mcnt == MOD_LAST);
        o_stat.req_type = r_req.req_type;
        o_stat.put_room = !(put_end > {1'b0, r_log_end}) && (r_append != 32'd0) &&
                          (r_append != OFF_TOMB) && (r_icnt < ICNT_MAX);
        o_stat.del_room = !(del_end > {1'b0, r_log_end});
        o_stat.done     = hit || empty || last;
        o_stat.hit      = hit;
        o_stat.have     = have;
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = r_word;
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (i_cmd.fin == FIN_PUT) begin
            we    = 1'b1;
            wdata = '{tag: r_req.tag, offset: r_append, key: r_req.key,
                      version: r_req.version};
        end else if (i_cmd.fin == FIN_DEL) begin
            we           = 1'b1;
            wdata.offset = OFF_TOMB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (i_cmd.rd) r_rd <= r_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_log_end   <= LOG_END_RST;
            r_append    <= LOG_START_RST;
            r_icnt      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOG_START: r_append <= i_cfg_data;
                    CFG_LOG_END: r_log_end <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.fin == FIN_PUT) begin
                r_icnt   <= r_icnt + IW'(1);
                r_append <= (put_next[33:32] != 2'd0) ? OFF_TOMB : put_next[31:0];
            end else if (i_cmd.fin == FIN_DEL) begin
                r_append <= del_end[31:0];
            end
            r_strobe <= (i_cmd.fin != FIN_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_request;
            r_mcnt <= '0;
        end
        // first step loads the fold, then compare and subtract shifted table sizes
        if (i_cmd.mod_step) begin
            if (r_mcnt == '0) begin
                r_fold <= fold_sum;
                r_div  <= TOP_DIV;
            end else begin
                if (r_fold >= r_div) r_fold <= r_fold - r_div;
                r_div <= r_div >> 1;
            end
            r_mcnt <= r_mcnt + MW'(1);
        end
        if (i_cmd.init) begin
            r_b       <= r_fold[AW-1:0];
            r_n       <= '0;
            r_dead    <= '0;
            r_dead_ok <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_b       <= (r_b == LAST_B) ? '0 : r_b + AW'(1);
            r_n       <= r_n + AW'(1);
            r_dead    <= dead2;
            r_dead_ok <= ok2;
            r_slot    <= slot;
            r_word    <= r_rd;
        end
        case (i_cmd.fin)
            FIN_MISS: r_res <= '{status: ST_NOT_FOUND, record_offset: '0, found_version: '0};
            FIN_FULL: r_res <= '{status: ST_FULL, record_offset: '0, found_version: '0};
            FIN_GET:  r_res <= '{status: ST_OK, record_offset: r_rd.offset,
                                 found_version: r_rd.version};
            FIN_PUT:  r_res <= '{status: ST_OK, record_offset: r_append, found_version: '0};
            FIN_DEL:  r_res <= '{status: ST_OK, record_offset: r_word.offset,
                                 found_version: '0};
            default: ;
        endcase
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

[hw/rtl/hashed_log_index_core.sv]
// Top level of the hashed log index: controller plus datapath.
// After reset the block clears its bucket table, one bucket a cycle, with
// busy high. A request is taken when start is high and busy is low. It then
// reduces key_digest to the home bucket (one weighted byte fold, then eleven
// compare-and-subtract steps), passes one setup state, a read state and an
// evaluate state per bucket probed (the bucket memory has one registered
// read port), and a write state for a successful put or delete; the result
// word shows on o_result for one cycle with o_strobe, in the first cycle that
// busy is low again. The receiver must take it then: there is no way to hold
// it. Configuration writes are always ready and are meant to be issued only
// while the block is idle.
module hashed_log_index_core #(
    parameter int unsigned TABLE_ENTRIES = hli_pkg::TABLE_ENTRIES_DEF,
    parameter int unsigned INDEX_ENTRIES = hli_pkg::INDEX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  hli_pkg::t_request i_request,
    output hli_pkg::t_result  o_result,
    output logic              o_strobe,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import hli_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    hli_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .INDEX_ENTRIES (INDEX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_request   (i_request),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule

[hw/rtl/hli_checker.sv]
// Port-level checks for the hashed log index, bound to the top level.
module hli_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input hli_pkg::t_result o_result,
    input logic             o_strobe
);
    import hli_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_strobe))
        else $error("accepted request did not raise busy");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result words back to back");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!o_busy && $past(o_busy)))
        else $error("result word outside end of request");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |->
        (o_result.record_offset == 32'd0 && o_result.found_version == 64'd0 &&
         (o_result.status == ST_NOT_FOUND || o_result.status == ST_FULL)))
        else $error("failed request returned data");

endmodule

bind hashed_log_index_core hli_checker u_hli_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);

[verif/testbench.sv]
// Self-checking testbench for hashed_log_index_core against a shadow model.
module testbench;
    import hli_pkg::*;

    localparam int unsigned TBL = TABLE_ENTRIES_DEF;
    localparam int unsigned IDX = INDEX_ENTRIES_DEF;
    localparam int unsigned CYCLE_LIMIT = 16000000;

    // Shadow of the index: predicts one result word per accepted request.
    class index_shadow;
        logic [31:0] log_start, log_end, append_offset;
        logic [31:0] b_tag[TBL], b_off[TBL], i_off[IDX], i_inv[IDX], i_tag[IDX];
        logic [63:0] b_key[TBL], b_ver[TBL];
        int unsigned index_count;
        t_result pending_results[$];
        int errors, checked;

        function new();
            log_start = LOG_START_RST;
            log_end = LOG_END_RST;
            append_offset = LOG_START_RST;
            index_count = 0;
            errors = 0;
            checked = 0;
            for (int i = 0; i < TBL; i++) begin
                b_tag[i] = '0;
                b_off[i] = '0;
                b_key[i] = '0;
                b_ver[i] = '0;
            end
            for (int i = 0; i < IDX; i++) begin
                i_off[i] = '0;
                i_inv[i] = '0;
                i_tag[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == CFG_LOG_START) begin
                log_start = data;
                append_offset = data;
            end else if (idx == CFG_LOG_END) begin
                log_end = data;
            end
        endfunction

        // Linear probe; a tombstone with the same tag beats an earlier one.
        function bit probe(t_request r, output int unsigned slot, output bit have);
            int unsigned home, b, dead;
            bit dead_ok;
            home = 32'(r.key_digest % 64'(TBL));
            dead_ok = 0;
            dead = 0;
            for (int n = 0; n < TBL; n++) begin
                b = (home + n) % TBL;
                if (b_tag[b] == r.tag && b_off[b] == OFF_TOMB) begin
                    dead = b;
                    dead_ok = 1;
                end else if (b_tag[b] == r.tag && b_off[b] != 0 && b_key[b] == r.key) begin
                    slot = b;
                    have = 1;
                    return 1;
                end
                if (b_off[b] == 0) begin
                    slot = dead_ok ? dead : b;
                    have = 1;
                    return 0;
                end
                if (b_off[b] == OFF_TOMB && !dead_ok) begin
                    dead = b;
                    dead_ok = 1;
                end
            end
            slot = dead;
            have = dead_ok;
            return 0;
        endfunction

        function void invalidate(logic [31:0] target, logic [31:0] with_off);
            int lo, hi, mid;
            lo = 0;
            hi = IDX - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (i_off[mid] == 0 || i_off[mid] > target) hi = mid - 1;
                else if (i_off[mid] < target) lo = mid + 1;
                else begin
                    i_inv[mid] = with_off;
                    return;
                end
            end
        endfunction

        function void note_request(t_request r);
            t_result res;
            int unsigned slot;
            bit have, hit;
            logic [32:0] tail, next;
            res = '{status: ST_NOT_FOUND, record_offset: '0, found_version: '0};
            slot = 0;
            have = 0;
            if (r.req_type == REQ_GET) begin
                if (probe(r, slot, have)) begin
                    res.status = ST_OK;
                    res.record_offset = b_off[slot];
                    res.found_version = b_ver[slot];
                end
            end else if (r.req_type == REQ_PUT) begin
                tail = {1'b0, append_offset} + {1'b0, r.record_bytes};
                if (tail > {1'b0, log_end} || append_offset == 0 || append_offset == OFF_TOMB
                    || index_count >= IDX - 1) begin
                    res.status = ST_FULL;
                end else begin
                    hit = probe(r, slot, have);
                    if (!have) res.status = ST_FULL;
                    else begin
                        next = (tail + 33'd7) & ~33'd7;
                        if (hit) invalidate(b_off[slot], append_offset);
                        i_tag[index_count] = r.search_tag;
                        i_inv[index_count] = '0;
                        i_off[index_count] = append_offset;
                        b_tag[slot] = r.tag;
                        b_off[slot] = append_offset;
                        b_key[slot] = r.key;
                        b_ver[slot] = r.version;
                        index_count++;
                        res.status = ST_OK;
                        res.record_offset = append_offset;
                        append_offset = next[32] ? OFF_TOMB : next[31:0];
                    end
                end
            end else if (r.req_type == REQ_DEL) begin
                if (probe(r, slot, have)) begin
                    if ({1'b0, append_offset} + 33'd8 > {1'b0, log_end}) res.status = ST_FULL;
                    else begin
                        res.record_offset = b_off[slot];
                        invalidate(b_off[slot], append_offset);
                        append_offset += 32'd8;
                        b_off[slot] = OFF_TOMB;
                        res.status = ST_OK;
                    end
                end
            end
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.record_offset !== want.record_offset
                || got.found_version !== want.found_version) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected st=%0d off=%h ver=%h, got st=%0d off=%h ver=%h",
                             want.status, want.record_offset, want.found_version,
                             got.status, got.record_offset, got.found_version);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start, i_cfg_valid;
    logic [1:0] i_cfg_index;
    logic [31:0] i_cfg_data;
    t_request i_request;
    t_result o_result;
    logic o_busy, o_strobe, o_cfg_ready;

    hashed_log_index_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_request(i_request), .o_result(o_result), .o_strobe(o_strobe),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    index_shadow shadow = new();
    int unsigned cycles = 0, sent = 0, reg_writes = 0, full_seen = 0;
    bit quiet = 0;

    logic [63:0] pool_key[48], pool_hash[48];
    logic [31:0] pool_tag[48];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** hashed_log_index_core: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_strobe) begin
            if (o_result.status == ST_FULL) full_seen <= full_seen + 1;
            shadow.check_result(o_result);
        end

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 99) < 9) repeat ($urandom_range(1, 8)) @(posedge i_clk);
    endtask

    task automatic send(t_request r);
        idle_gap();
        @(posedge i_clk);
        i_request <= r;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        shadow.note_request(r);
        i_start <= 1'b0;
        sent++;
    endtask

    task automatic drain();
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    function automatic t_request req(logic [1:0] op, logic [63:0] key, logic [63:0] hash,
                                     logic [31:0] tag, logic [31:0] rbytes);
        t_request r;
        r.req_type = op;
        r.key = key;
        r.key_digest = hash;
        r.tag = tag;
        r.search_tag = $urandom;
        r.record_bytes = rbytes;
        r.version = {$urandom, $urandom};
        return r;
    endfunction

    // Mostly pool keys so gets, overwrites and deletes hit; some noise.
    function automatic t_request random_req();
        int unsigned p, pick;
        logic [1:0] op;
        logic [31:0] rb;
        pick = $urandom_range(0, 99);
        op = pick < 38 ? REQ_PUT : pick < 68 ? REQ_GET : pick < 95 ? REQ_DEL : REQ_NONE;
        rb = ($urandom_range(0, 99) < 3) ? $urandom : $urandom_range(0, 300);
        if ($urandom_range(0, 99) < 10)
            return req(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, rb);
        p = $urandom_range(0, 47);
        return req(op, pool_key[p], pool_hash[p], pool_tag[p], rb);
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            quiet = (i >= n / 3) && (i < n / 2);
            send(random_req());
        end
        quiet = 0;
    endtask

    initial begin
        logic [63:0] ka, kb, kc;
        i_rst_n = 0;
        i_start = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_LOG_START;
        i_cfg_data = '0;
        i_request = '0;
        for (int i = 0; i < 48; i++) begin
            pool_key[i] = {$urandom, $urandom};
            // crowd a few home buckets, including the wrap at the top
            pool_hash[i] = {$urandom, $urandom};
            if (i < 24) pool_hash[i][9:0] = (i % 2) ? 10'(1022 + i % 3) : 10'(i % 4);
            pool_tag[i] = (i < 12) ? 32'd5 : $urandom;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        ka = 64'h1111;
        kb = 64'h2222;
        kc = '1;
        send(req(REQ_GET, '0, '0, '0, '0));            // empty bucket, equal zero tag
        send(req(REQ_PUT, ka, '0, '0, '0));
        send(req(REQ_GET, ka, '0, '0, '0));
        send(req(REQ_PUT, ka, 64'd1024, '0, 32'd13));  // overwrite, old entry invalidated
        send(req(REQ_PUT, kb, '0, '0, 32'd7));         // same tag, next bucket
        send(req(REQ_GET, kb, '0, '0, '0));
        send(req(REQ_DEL, ka, '0, '0, '0));            // leaves a tombstone
        send(req(REQ_GET, ka, '0, '0, '0));
        send(req(REQ_DEL, ka, '0, '0, '0));
        send(req(REQ_PUT, kc, '0, 32'd9, 32'd1));      // reuses tombstone
        send(req(REQ_GET, kb, '0, '0, '0));
        send(req(REQ_NONE, ka, '0, '0, '0));
        send(req(REQ_PUT, kc, '1, '1, 32'd100));       // home bucket at the top
        send(req(REQ_GET, kc, '1, '1, '0));
        send(req(REQ_PUT, kc, '1, '1, '1));            // record too large
        send(req(REQ_DEL, kc, '1, '1, '0));
        send(req(REQ_GET, kc, '1, '1, '0));

        // pointer saturation at the top of the offset space
        write_reg(CFG_LOG_END, 32'hFFFF_FFFE);
        write_reg(CFG_LOG_START, 32'hFFFF_FFF0);
        send(req(REQ_PUT, ka, 64'd77, 32'd3, 32'd10));
        send(req(REQ_PUT, kb, 64'd78, 32'd3, 32'd0));
        send(req(REQ_DEL, ka, 64'd77, 32'd3, '0));
        send(req(REQ_GET, ka, 64'd77, 32'd3, '0));

        // tightest log
        write_reg(CFG_LOG_START, 32'd8);
        write_reg(CFG_LOG_END, 32'd8);
        send(req(REQ_PUT, ka, 64'd90, 32'd4, '0));
        send(req(REQ_DEL, ka, 64'd90, 32'd4, '0));

        write_reg(CFG_LOG_END, 32'h4000_0000);
        random_run(300);
        drain();                                       // sender holds off until all results arrive
        random_run(200);
        write_reg(CFG_LOG_START, 32'd8);
        write_reg(CFG_LOG_END, 32'hFFFF_FFFE);
        random_run(350);
        write_reg(CFG_LOG_START, 32'h0010_0000 + $urandom_range(0, 4096));
        write_reg(CFG_LOG_END, 32'h0010_0000 + 32'd6000);
        random_run(300);
        write_reg(CFG_LOG_START, 32'hFFFF_FFF8);
        write_reg(CFG_LOG_END, 32'hFFFF_FFFE);
        random_run(100);
        write_reg(CFG_LOG_START, 32'h0800_0000);
        write_reg(CFG_LOG_END, 32'h1000_0000);
        random_run(250);

        drain();
        repeat (200) @(posedge i_clk);
        $display("requests sent %0d, results checked %0d, full answers %0d, register writes %0d",
                 sent, shadow.checked, full_seen, reg_writes);
        $display("search index entries used %0d of %0d, mismatches %0d",
                 shadow.index_count, IDX, shadow.errors);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0)
            $display("** hashed_log_index_core: PASSED **");
        else
            $display("** hashed_log_index_core: FAILED **");
        $finish;
    end
endmodule

[hashed_log_index_core.f]
hw/rtl/hli_pkg.sv
hw/rtl/hli_ctrl.sv
hw/rtl/hli_dp.sv
hw/rtl/hashed_log_index_core.sv
hw/rtl/hli_checker.sv
verif/testbench.sv
